// File: sv/bzease_pkg.sv
// ----------------------------------------------------------------------------
// bzease_pkg
// Shared widths, constants, types and fixed-point helpers for the cubic
// Bezier easing evaluator.
// ----------------------------------------------------------------------------
package bzease_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int NEWTON_STEPS = 12;

   localparam int TW  = FRAC_BITS + 1;
   localparam int KW  = 12;
   localparam int SW  = FRAC_BITS + 15;
   localparam int MW  = FRAC_BITS + 13;
   localparam int RS  = MW + 7;
   localparam int FW  = FRAC_BITS + 5;
   localparam int QB  = FRAC_BITS + 2;
   localparam int NW  = FW + FRAC_BITS + 1;
   localparam int UP  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int DN  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int HALF_UP = (UP > 0) ? (1 << (UP - 1)) : 0;
   localparam int HALF_DN = (DN > 0) ? (1 << (DN - 1)) : 0;

   localparam longint RECIP_L = ((longint'(1) << RS) + 126) / 127;
   localparam logic [MW:0] RECIP127 = RECIP_L[MW:0];

   localparam logic [TW-1:0] ONE_F   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [16:0]   Q16_ONE = 17'h10000;
   localparam logic [15:0]   EPS_RESET = 16'd1;

   typedef logic [2*TW-1:0] fprod_type;
   typedef logic [TW+17:0]  wide_type;
   typedef logic [2*MW:0]   rprod_type;

   typedef struct packed {
      logic                 diag;
      logic [16:0]          xq;
      logic [TW-1:0]        x;
      logic [TW-1:0]        t;
      logic signed [KW-1:0] k0;
      logic signed [KW-1:0] k1;
      logic signed [KW-1:0] k2;
      logic [6:0]           a_y;
      logic [6:0]           b_y;
      logic                 done;
   } ctx_type;

   function automatic logic [TW-1:0] fmul(input logic [TW-1:0] a, input logic [TW-1:0] b);
      fprod_type p;
      p = fprod_type'(a) * fprod_type'(b) + fprod_type'(ONE_F >> 1);
      return p[FRAC_BITS +: TW];
   endfunction

   function automatic logic [TW-1:0] from_q16(input logic [16:0] v);
      wide_type w;
      w = ((wide_type'(v) << UP) + wide_type'(HALF_DN)) >> DN;
      return w[TW-1:0];
   endfunction

   function automatic logic [16:0] to_q16(input logic [TW-1:0] v);
      wide_type w;
      w = ((wide_type'(v) + wide_type'(HALF_UP)) >> UP) << DN;
      if (w > wide_type'(Q16_ONE)) begin
         w = wide_type'(Q16_ONE);
      end
      return w[16:0];
   endfunction

endpackage

// File: sv/bzease_newton_step.sv
// ----------------------------------------------------------------------------
// bzease_newton_step
// One pipelined Newton iteration: curve residual and slope, early-stop test,
// a bit-per-stage restoring divider for the correction and the clamped update.
// ----------------------------------------------------------------------------
module bzease_newton_step
   import bzease_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic [TW-1:0] eps,
   input  logic          in_vld,
   input  ctx_type       in_ctx,
   output logic          out_vld,
   output ctx_type       out_ctx
);

   typedef struct packed {
      logic [FW-1:0] rem;
      logic [QB-1:0] nlo;
      logic [QB-1:0] q;
      logic [FW-1:0] d;
      logic          neg;
      logic          ovf;
   } div_type;

   localparam logic signed [SW-1:0] C2    = SW'(2);
   localparam logic signed [SW-1:0] C3    = SW'(3);
   localparam logic signed [SW-1:0] ONE_S = SW'(ONE_F);

   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff, f_vld_ff, h_vld_ff;
   ctx_type a_ctx_ff, b_ctx_ff, c_ctx_ff, d_ctx_ff, e_ctx_ff, f_ctx_ff, h_ctx_ff;
   logic [TW-1:0] a_t2_ff, b_t2_ff, b_t3_ff;
   logic signed [SW-1:0] c_sf_ff, c_sd_ff, c_sf_in, c_sd_in;
   logic [MW-1:0] d_mf_ff, d_md_ff;
   logic d_sgf_ff, d_sgd_ff;
   rprod_type e_pf_ff, e_pd_ff;
   logic e_sgf_ff, e_sgd_ff;
   logic signed [SW-1:0] f_ft_ff, f_dft_ff, f_ft_in, f_dft_in;
   logic [MW-7:0] f_qf, f_qd;
   logic signed [SW-1:0] f_qfs, f_qds;

   logic dv_vld_ff [QB+1];
   div_type dv_ff [QB+1];
   ctx_type dv_ctx_ff [QB+1];
   div_type dv_in;
   ctx_type g_ctx_in;
   logic [SW-1:0] g_aft_w, g_adft_w;
   logic [FW-1:0] g_aft, g_adft;
   logic [NW-1:0] g_n;

   logic [QB-1:0] h_q;
   logic [QB:0] h_sum, h_diff;
   ctx_type h_ctx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= in_vld;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
         h_vld_ff <= dv_vld_ff[QB];
      end
   end

   always_comb begin
      c_sf_in = SW'(b_ctx_ff.k0) * $signed(SW'(b_t3_ff))
              + SW'(b_ctx_ff.k1) * $signed(SW'(b_t2_ff))
              + SW'(b_ctx_ff.k2) * $signed(SW'(b_ctx_ff.t));
      c_sd_in = C3 * SW'(b_ctx_ff.k0) * $signed(SW'(b_t2_ff))
              + C2 * SW'(b_ctx_ff.k1) * $signed(SW'(b_ctx_ff.t))
              + SW'(b_ctx_ff.k2) * ONE_S;
   end

   always_comb begin
      f_qf     = e_pf_ff[2*MW:RS];
      f_qd     = e_pd_ff[2*MW:RS];
      f_qfs    = e_sgf_ff ? -$signed(SW'(f_qf)) : $signed(SW'(f_qf));
      f_qds    = e_sgd_ff ? -$signed(SW'(f_qd)) : $signed(SW'(f_qd));
      f_ft_in  = f_qfs - $signed(SW'(e_ctx_ff.x));
      f_dft_in = f_qds;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ctx_ff <= in_ctx;
         a_t2_ff  <= fmul(in_ctx.t, in_ctx.t);
         b_ctx_ff <= a_ctx_ff;
         b_t2_ff  <= a_t2_ff;
         b_t3_ff  <= fmul(a_t2_ff, a_ctx_ff.t);
         c_ctx_ff <= b_ctx_ff;
         c_sf_ff  <= c_sf_in;
         c_sd_ff  <= c_sd_in;
         d_ctx_ff <= c_ctx_ff;
         d_sgf_ff <= c_sf_ff[SW-1];
         d_sgd_ff <= c_sd_ff[SW-1];
         d_mf_ff  <= (c_sf_ff[SW-1] ? MW'(-c_sf_ff) : MW'(c_sf_ff)) + MW'(63);
         d_md_ff  <= (c_sd_ff[SW-1] ? MW'(-c_sd_ff) : MW'(c_sd_ff)) + MW'(63);
         e_ctx_ff <= d_ctx_ff;
         e_sgf_ff <= d_sgf_ff;
         e_sgd_ff <= d_sgd_ff;
         e_pf_ff  <= rprod_type'(d_mf_ff) * rprod_type'(RECIP127);
         e_pd_ff  <= rprod_type'(d_md_ff) * rprod_type'(RECIP127);
         f_ctx_ff <= e_ctx_ff;
         f_ft_ff  <= f_ft_in;
         f_dft_ff <= f_dft_in;
      end
   end

   always_comb begin
      g_aft_w  = f_ft_ff[SW-1] ? SW'(-f_ft_ff) : SW'(f_ft_ff);
      g_adft_w = f_dft_ff[SW-1] ? SW'(-f_dft_ff) : SW'(f_dft_ff);
      g_aft    = g_aft_w[FW-1:0];
      g_adft   = g_adft_w[FW-1:0];
      g_n      = NW'({g_aft, {FRAC_BITS{1'b0}}}) + NW'(g_adft >> 1);
      g_ctx_in = f_ctx_ff;
      g_ctx_in.done = f_ctx_ff.done || (g_aft <= FW'(eps)) || (g_adft <= FW'(eps));
      dv_in.rem = {1'b0, g_n[NW-1:QB]};
      dv_in.nlo = g_n[QB-1:0];
      dv_in.q   = '0;
      dv_in.d   = g_adft;
      dv_in.neg = f_ft_ff[SW-1] ^ f_dft_ff[SW-1];
      dv_in.ovf = ({1'b0, g_n[NW-1:QB]} >= g_adft);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_vld_ff[0] <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_ff[0]     <= dv_in;
         dv_ctx_ff[0] <= g_ctx_in;
      end
   end

   for (genvar i = 1; i <= QB; i++) begin : g_div
      logic [FW:0] trial;
      logic [FW:0] diff;
      logic        ge;
      div_type     nxt_in;

      always_comb begin
         trial      = {dv_ff[i-1].rem, dv_ff[i-1].nlo[QB-1]};
         ge         = (trial >= {1'b0, dv_ff[i-1].d});
         diff       = trial - {1'b0, dv_ff[i-1].d};
         nxt_in     = dv_ff[i-1];
         nxt_in.rem = ge ? diff[FW-1:0] : trial[FW-1:0];
         nxt_in.nlo = dv_ff[i-1].nlo << 1;
         nxt_in.q   = {dv_ff[i-1].q[QB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[i] <= 1'b0;
         end else if (advance) begin
            dv_vld_ff[i] <= dv_vld_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_ff[i]     <= nxt_in;
            dv_ctx_ff[i] <= dv_ctx_ff[i-1];
         end
      end
   end

   always_comb begin
      h_q      = dv_ff[QB].ovf ? '1 : dv_ff[QB].q;
      h_sum    = (QB+1)'(dv_ctx_ff[QB].t) + (QB+1)'(h_q);
      h_diff   = (QB+1)'(dv_ctx_ff[QB].t) - (QB+1)'(h_q);
      h_ctx_in = dv_ctx_ff[QB];
      if (!dv_ctx_ff[QB].done) begin
         if (dv_ff[QB].neg) begin
            h_ctx_in.t = (h_sum > (QB+1)'(ONE_F)) ? ONE_F : h_sum[TW-1:0];
         end else begin
            h_ctx_in.t = h_diff[QB] ? '0 : h_diff[TW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h_ctx_ff <= h_ctx_in;
      end
   end

   assign out_vld = h_vld_ff;
   assign out_ctx = h_ctx_ff;

endmodule

// File: sv/bezier_ease_y_from_x.sv
// ----------------------------------------------------------------------------
// bezier_ease_y_from_x
// Cubic Bezier easing: solves x(t) = x by unrolled Newton steps and returns
// y(t), all in one fully pipelined datapath.
//
//   Channel  Direction  Handshake                Payload
//   req      in         req_valid / req_ready    x_progress, p1_x, p1_y, p2_x, p2_y
//   rsp      out        rsp_valid / rsp_ready    y_value
//   csr      in         csr_wr_en                csr_wr_data (epsilon)
//
// One item is accepted per cycle while no result is stalled; each Newton step
// is 7 + FRAC_BITS + 2 + 1 stages (the restoring divider takes one quotient bit
// a stage).
// Reset is synchronous and clears every valid bit; epsilon resets to the raw value 1.
// A stalled result freezes the whole pipeline, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module bezier_ease_y_from_x
   import bzease_pkg::*;
#(
   parameter int NEWTON_STEPS = bzease_pkg::NEWTON_STEPS
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [16:0] req_x_progress,
   input  logic [6:0]  req_p1_x,
   input  logic [6:0]  req_p1_y,
   input  logic [6:0]  req_p2_x,
   input  logic [6:0]  req_p2_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [16:0] rsp_y_value,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam logic signed [KW-1:0] K127 = KW'(127);
   localparam logic signed [KW-1:0] K3   = KW'(3);
   localparam logic signed [KW-1:0] K6   = KW'(6);

   logic          advance;
   logic [15:0]   eps_ff;
   logic [TW-1:0] eps_f;

   logic          st_vld [NEWTON_STEPS+1];
   ctx_type       st_ctx [NEWTON_STEPS+1];
   logic          i_vld_ff;
   ctx_type       i_ctx_ff, i_ctx_in;
   logic [16:0]   xq_sat;
   logic signed [KW-1:0] ax, bx;

   logic          e1_vld_ff, e2_vld_ff, e3_vld_ff, e4_vld_ff;
   ctx_type       e1_ctx_ff, e2_ctx_ff, e3_ctx_ff, e4_ctx_ff;
   logic [TW-1:0] e1_r, e1_r_ff, e1_t2_ff, e1_r2_ff;
   logic [TW-1:0] e2_t3_ff, e2_t2r_ff, e2_tr2_ff;
   logic [TW-1:0] e3_t3_ff, e4_t3_ff;
   logic [MW-1:0] e3_num_ff;
   rprod_type     e4_prod_ff;
   logic [MW-6:0] ys;
   logic [TW-1:0] yc;
   logic          rsp_valid_ff;
   logic [16:0]   rsp_y_value_ff, rsp_y_value_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign eps_f     = from_q16({1'b0, eps_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   always_comb begin
      xq_sat = (req_x_progress > Q16_ONE) ? Q16_ONE : req_x_progress;
      ax = $signed(KW'(req_p1_x));
      bx = $signed(KW'(req_p2_x));
      i_ctx_in.diag = (req_p1_x == req_p1_y) && (req_p2_x == req_p2_y);
      i_ctx_in.xq   = xq_sat;
      i_ctx_in.x    = from_q16(xq_sat);
      i_ctx_in.t    = from_q16(xq_sat);
      i_ctx_in.k0   = K127 + K3 * ax - K3 * bx;
      i_ctx_in.k1   = K3 * bx - K6 * ax;
      i_ctx_in.k2   = K3 * ax;
      i_ctx_in.a_y  = req_p1_y;
      i_ctx_in.b_y  = req_p2_y;
      i_ctx_in.done = i_ctx_in.diag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff <= 1'b0;
      end else if (advance) begin
         i_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         i_ctx_ff <= i_ctx_in;
      end
   end

   assign st_vld[0] = i_vld_ff;
   assign st_ctx[0] = i_ctx_ff;

   for (genvar s = 0; s < NEWTON_STEPS; s++) begin : g_step
      bzease_newton_step u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .eps     (eps_f),
         .in_vld  (st_vld[s]),
         .in_ctx  (st_ctx[s]),
         .out_vld (st_vld[s+1]),
         .out_ctx (st_ctx[s+1])
      );
   end

   assign e1_r = ONE_F - st_ctx[NEWTON_STEPS].t;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff    <= 1'b0;
         e2_vld_ff    <= 1'b0;
         e3_vld_ff    <= 1'b0;
         e4_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         e1_vld_ff    <= st_vld[NEWTON_STEPS];
         e2_vld_ff    <= e1_vld_ff;
         e3_vld_ff    <= e2_vld_ff;
         e4_vld_ff    <= e3_vld_ff;
         rsp_valid_ff <= e4_vld_ff;
      end
   end

   always_comb begin
      ys = (MW-5)'(e4_t3_ff) + e4_prod_ff[2*MW:RS];
      yc = (ys > (MW-5)'(ONE_F)) ? ONE_F : ys[TW-1:0];
      rsp_y_value_in = e4_ctx_ff.diag ? e4_ctx_ff.xq : to_q16(yc);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e1_ctx_ff      <= st_ctx[NEWTON_STEPS];
         e1_r_ff        <= e1_r;
         e1_t2_ff       <= fmul(st_ctx[NEWTON_STEPS].t, st_ctx[NEWTON_STEPS].t);
         e1_r2_ff       <= fmul(e1_r, e1_r);
         e2_ctx_ff      <= e1_ctx_ff;
         e2_t3_ff       <= fmul(e1_t2_ff, e1_ctx_ff.t);
         e2_t2r_ff      <= fmul(e1_t2_ff, e1_r_ff);
         e2_tr2_ff      <= fmul(e1_ctx_ff.t, e1_r2_ff);
         e3_ctx_ff      <= e2_ctx_ff;
         e3_t3_ff       <= e2_t3_ff;
         e3_num_ff      <= MW'(3) * (MW'(e2_ctx_ff.b_y) * MW'(e2_t2r_ff)
                                   + MW'(e2_ctx_ff.a_y) * MW'(e2_tr2_ff)) + MW'(63);
         e4_ctx_ff      <= e3_ctx_ff;
         e4_t3_ff       <= e3_t3_ff;
         e4_prod_ff     <= rprod_type'(e3_num_ff) * rprod_type'(RECIP127);
         rsp_y_value_ff <= rsp_y_value_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_y_value = rsp_y_value_ff;

endmodule

// File: sv/bzease_checker.sv
// ----------------------------------------------------------------------------
// bzease_checker
// Port-level checks for the easing evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bzease_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [16:0] rsp_y_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_y_value))
      else $error("result item changed while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_y_value <= 17'h10000)
      else $error("result above one");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input refused without an output stall");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind bezier_ease_y_from_x bzease_checker u_bzease_checker (.*);

// File: bench/bezier_ease_y_from_x_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bezier_ease_y_from_x_tb
// Drives the Bezier easing evaluator with a table of directed items and then
// random curves under several epsilon settings. Each result is checked
// against a fixed-point Newton solver written into this bench.
// ----------------------------------------------------------------------------
module bezier_ease_y_from_x_tb;
   import bzease_pkg::*;

   localparam int LATENCY   = 1 + NEWTON_STEPS * (FRAC_BITS + 10) + 5;
   localparam int LIMIT     = 600000;
   localparam int N_PHASES  = 7;
   localparam int PER_PHASE = 250;
   localparam int HOLD_LEN  = 900;

   typedef struct {
      logic [16:0] x;
      logic [6:0]  ax, ay, bx, by;
      bit          known;
      logic [16:0] y;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [16:0] req_x_progress = '0;
   logic [6:0]  req_p1_x = '0, req_p1_y = '0, req_p2_x = '0, req_p2_y = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [16:0] rsp_y_value;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   logic [16:0] y_pending[$];
   logic [15:0] eps_now = EPS_RESET;
   int          errors = 0;
   int          cycles = 0;
   int          sent = 0;
   int          checked = 0;
   bit          calm = 1'b0;
   bit          hold_req = 1'b0;
   row_type     dir_rows[$];

   bezier_ease_y_from_x i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_progress(req_x_progress),
      .req_p1_x(req_p1_x), .req_p1_y(req_p1_y),
      .req_p2_x(req_p2_x), .req_p2_y(req_p2_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_y_value(rsp_y_value),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint fix_mul(input longint a, input longint b);
      return (a * b + 32768) >>> FRAC_BITS;
   endfunction

   function automatic longint round_div(input longint n, input longint d);
      longint un, ud, q;
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = (un + ud / 2) / ud;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic logic [16:0] ease_y(input logic [16:0] xin, input logic [6:0] ax,
                                          input logic [6:0] ay, input logic [6:0] bx,
                                          input logic [6:0] by, input logic [15:0] e);
      longint x, t, eps, k0, k1, k2, t2, t3, ft, dft, r, y;
      logic [16:0] xq;
      xq = (xin > Q16_ONE) ? Q16_ONE : xin;
      if (ax == ay && bx == by) return xq;
      x = xq;
      eps = e;
      k0 = 127 + 3 * longint'(ax) - 3 * longint'(bx);
      k1 = 3 * longint'(bx) - 6 * longint'(ax);
      k2 = 3 * longint'(ax);
      t = x;
      for (int i = 0; i < NEWTON_STEPS; i++) begin
         t2 = fix_mul(t, t);
         t3 = fix_mul(t2, t);
         ft = round_div(k0 * t3 + k1 * t2 + k2 * t, 127) - x;
         if (((ft < 0) ? -ft : ft) <= eps) break;
         dft = round_div(3 * k0 * t2 + 2 * k1 * t + k2 * 65536, 127);
         if (((dft < 0) ? -dft : dft) <= eps) break;
         t = t - round_div(ft * 65536, dft);
         if (t < 0) t = 0;
         if (t > 65536) t = 65536;
      end
      r = 65536 - t;
      t2 = fix_mul(t, t);
      t3 = fix_mul(t2, t);
      y = t3 + round_div(3 * longint'(by) * fix_mul(t2, r)
                         + 3 * longint'(ay) * fix_mul(t, fix_mul(r, r)), 127);
      if (y < 0) y = 0;
      if (y > 65536) y = 65536;
      return y[16:0];
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("%0t: run exceeded its cycle limit", $time);
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            y_pending = {y_pending, ease_y(req_x_progress, req_p1_x, req_p1_y,
                                           req_p2_x, req_p2_y, eps_now)};
         end
         if (rsp_valid && rsp_ready) begin
            if (y_pending.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d", $time,
                        rsp_y_value);
               errors++;
            end else begin
               if (rsp_y_value !== y_pending[0]) begin
                  $display("%0t: y_value mismatch, expected %0d, actual %0d", $time,
                           y_pending[0], rsp_y_value);
                  errors++;
               end
               void'(y_pending.pop_front());
               checked++;
            end
         end
         if (csr_wr_en) eps_now = csr_wr_data;
      end
   end

   // The receiver; on request it holds off for a long stretch to fill the pipeline.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            hold_req = 1'b0;
         end
         stall = calm ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_item(input logic [16:0] x, input logic [6:0] ax, input logic [6:0] ay,
                            input logic [6:0] bx, input logic [6:0] by);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_x_progress <= x;
      req_p1_x <= ax;
      req_p1_y <= ay;
      req_p2_x <= bx;
      req_p2_y <= by;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic settle_and_write(input logic [15:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (y_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [6:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 7'd0;
         1: return 7'd127;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   task automatic random_item();
      logic [16:0] x;
      logic [6:0]  ax, ay, bx, by;
      case ($urandom_range(0, 9))
         0: x = 17'($urandom_range(65537, 131071));
         1: x = ($urandom_range(0, 1) != 0) ? 17'd0 : Q16_ONE;
         default: x = 17'($urandom_range(0, 65536));
      endcase
      ax = pick_coord();
      ay = pick_coord();
      bx = pick_coord();
      by = pick_coord();
      if ($urandom_range(0, 9) == 0) begin
         ay = ax;
         by = bx;
      end
      send_item(x, ax, ay, bx, by);
   endtask

   initial begin
      logic [15:0] eps_list[N_PHASES];
      row_type     rw;
      eps_list = '{16'd0, 16'd65535, 16'd1, 16'($urandom_range(2, 4000)), 16'd0,
                   16'($urandom), 16'd1};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      dir_rows = '{
         '{17'd0,      7'd10,  7'd10,  7'd90,  7'd90,  1, 17'd0},
         '{17'd65536,  7'd33,  7'd33,  7'd5,   7'd5,   1, 17'd65536},
         '{17'd131071, 7'd0,   7'd0,   7'd127, 7'd127, 1, 17'd65536},
         '{17'd70000,  7'd127, 7'd127, 7'd0,   7'd0,   1, 17'd65536},
         '{17'd0,      7'd54,  7'd0,   7'd127, 7'd127, 1, 17'd0},
         '{17'd65536,  7'd54,  7'd0,   7'd127, 7'd127, 1, 17'd65536},
         '{17'd131071, 7'd127, 7'd0,   7'd0,   7'd127, 1, 17'd65536},
         '{17'd98304,  7'd30,  7'd100, 7'd60,  7'd20,  1, 17'd65536},
         '{17'd32768,  7'd54,  7'd0,   7'd127, 7'd127, 0, 17'd0},
         '{17'd32768,  7'd127, 7'd0,   7'd0,   7'd127, 0, 17'd0},
         '{17'd1,      7'd0,   7'd127, 7'd127, 7'd0,   0, 17'd0},
         '{17'd65535,  7'd0,   7'd127, 7'd127, 7'd0,   0, 17'd0},
         '{17'd21845,  7'd127, 7'd127, 7'd127, 7'd0,   0, 17'd0},
         '{17'd43690,  7'd0,   7'd0,   7'd0,   7'd127, 0, 17'd0},
         '{17'd12345,  7'd127, 7'd0,   7'd127, 7'd0,   0, 17'd0},
         '{17'd50000,  7'd0,   7'd127, 7'd0,   7'd127, 0, 17'd0},
         '{17'd40000,  7'd64,  7'd64,  7'd64,  7'd1,   0, 17'd0},
         '{17'd65536,  7'd0,   7'd127, 7'd127, 7'd0,   1, 17'd65536}
      };
      foreach (dir_rows[i]) begin
         rw = dir_rows[i];
         if (rw.known && rw.y !== ease_y(rw.x, rw.ax, rw.ay, rw.bx, rw.by, eps_now)) begin
            $display("%0t: directed row %0d, expected %0d, actual %0d", $time, i, rw.y,
                     ease_y(rw.x, rw.ax, rw.ay, rw.bx, rw.by, eps_now));
            errors++;
         end
         send_item(rw.x, rw.ax, rw.ay, rw.bx, rw.by);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         settle_and_write(eps_list[p]);
         calm = (p == 3);
         if (p == 2) hold_req = 1'b1;
         repeat (PER_PHASE) random_item();
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      while (y_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d items over %0d epsilon settings including 0 and 65535;", sent,
               N_PHASES + 1);
      $display("checked %0d results, with one long receiver hold-off.", checked);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: bezier_ease_y_from_x.f
sv/bzease_pkg.sv
sv/bzease_newton_step.sv
sv/bezier_ease_y_from_x.sv
sv/bzease_checker.sv
bench/bezier_ease_y_from_x_tb.sv
